[design/ltd_pkg.sv]
// shared types and codes for the bytecode line table decoder
// no dependencies; used by ltd_walk and bytecode_line_table_decoder
package ltd_pkg;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] FMT_PAIRS      = 2'd0;
    localparam logic [1:0] FMT_SKIP_PAIRS = 2'd1;
    localparam logic [1:0] FMT_ENTRIES    = 2'd2;

    localparam logic CFG_TABLE_FORMAT = 1'b0;
    localparam logic CFG_CODE_START   = 1'b1;

    // entry_phase codes
    localparam logic [2:0] PH_HEAD      = 3'd0;
    localparam logic [2:0] PH_VAR_DELTA = 3'd1;
    localparam logic [2:0] PH_VAR_LONG  = 3'd2;
    localparam logic [2:0] PH_SKIP_VAR  = 3'd3;
    localparam logic [2:0] PH_SKIP_BYTE = 3'd4;

    // entry head codes
    localparam logic [3:0] CODE_NONE     = 4'd15;
    localparam logic [3:0] CODE_LONG     = 4'd14;
    localparam logic [3:0] CODE_VARINT   = 4'd13;
    localparam logic [3:0] CODE_ONE_LINE = 4'd10;

    localparam logic [7:0] NO_LINE_DELTA = 8'h80;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         table_byte;
        logic signed [31:0] instr_offset;
        logic [30:0]        first_line;
    } item_t;

endpackage

[design/ltd_walk.sv]
// line table walk: state registers and the per-item update logic
// depends on ltd_pkg
module ltd_walk (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_en,
    input  ltd_pkg::item_t item,
    input  logic [1:0]    table_format,
    input  logic [15:0]   code_start_offset,
    output logic [31:0]   line_number
);

    logic [31:0] target_offset_reg, target_offset_next;
    logic [31:0] current_line_reg, current_line_next;
    logic [31:0] address_sum_reg, address_sum_next;
    logic        decided_reg, decided_next;
    logic [2:0]  entry_phase_reg, entry_phase_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic [31:0] varint_value_reg, varint_value_next;
    logic [4:0]  varint_shift_reg, varint_shift_next;
    logic [1:0]  skip_count_reg, skip_count_next;

    logic [7:0]  b;
    logic [31:0] entry_target;
    logic [31:0] varint_sum;
    logic [31:0] varint_mag;
    logic [31:0] varint_delta;
    logic [31:0] pair_sum;
    logic [31:0] head_sum;
    logic [3:0]  code;
    logic        varint_more;

    assign b            = item.table_byte;
    assign entry_target = target_offset_reg - {16'd0, code_start_offset};
    assign varint_sum   = varint_value_reg
                        + ((varint_shift_reg <= 5'd30)
                           ? ({26'd0, b[5:0]} << varint_shift_reg) : 32'd0);
    assign varint_mag   = varint_sum >> 1;
    assign varint_delta = varint_sum[0] ? (32'd0 - varint_mag) : varint_mag;
    assign varint_more  = b[6];
    assign pair_sum     = address_sum_reg + {24'd0, held_byte_reg};
    assign head_sum     = address_sum_reg + {27'd0, ({1'b0, b[2:0]} + 4'd1), 1'b0};
    assign code         = b[6:3];

    always_comb
    begin
        target_offset_next = target_offset_reg;
        current_line_next  = current_line_reg;
        address_sum_next   = address_sum_reg;
        decided_next       = decided_reg;
        entry_phase_next   = entry_phase_reg;
        held_byte_next     = held_byte_reg;
        varint_value_next  = varint_value_reg;
        varint_shift_next  = varint_shift_reg;
        skip_count_next    = skip_count_reg;

        if (item_en && item.kind == ltd_pkg::KIND_BEGIN)
        begin
            target_offset_next = item.instr_offset;
            current_line_next  = {1'b0, item.first_line};
            address_sum_next   = 32'd0;
            decided_next       = 1'b0;
            entry_phase_next   = ltd_pkg::PH_HEAD;
            held_byte_next     = 8'd0;
            varint_value_next  = 32'd0;
            varint_shift_next  = 5'd0;
            skip_count_next    = 2'd0;
        end
        else if (item_en && item.kind == ltd_pkg::KIND_BYTE && !decided_reg)
        begin
            if (table_format == ltd_pkg::FMT_PAIRS || table_format == ltd_pkg::FMT_SKIP_PAIRS)
            begin
                if (entry_phase_reg == ltd_pkg::PH_HEAD)
                begin
                    held_byte_next   = b;
                    entry_phase_next = ltd_pkg::PH_VAR_DELTA;
                end
                else
                begin
                    entry_phase_next = ltd_pkg::PH_HEAD;
                    if (table_format == ltd_pkg::FMT_PAIRS)
                    begin
                        address_sum_next = pair_sum;
                        if ($signed(pair_sum) > $signed(target_offset_reg))
                            decided_next = 1'b1;
                        else
                            current_line_next = current_line_reg + {{24{b[7]}}, b};
                    end
                    else if (b != ltd_pkg::NO_LINE_DELTA)
                    begin
                        current_line_next = current_line_reg + {{24{b[7]}}, b};
                        address_sum_next  = pair_sum;
                        if ($signed(pair_sum) > $signed({target_offset_reg[30:0], 1'b0}))
                            decided_next = 1'b1;
                    end
                end
            end
            else if (table_format == ltd_pkg::FMT_ENTRIES)
            begin
                case (entry_phase_reg)
                    ltd_pkg::PH_VAR_DELTA, ltd_pkg::PH_VAR_LONG:
                    begin
                        varint_value_next = varint_sum;
                        varint_shift_next = (varint_shift_reg <= 5'd24)
                                          ? varint_shift_reg + 5'd6 : 5'd31;
                        if (!varint_more)
                        begin
                            current_line_next = current_line_reg + varint_delta;
                            if ($signed(address_sum_reg) >= $signed(entry_target))
                                decided_next = 1'b1;
                            if (entry_phase_reg == ltd_pkg::PH_VAR_LONG)
                            begin
                                skip_count_next  = 2'd3;
                                entry_phase_next = ltd_pkg::PH_SKIP_VAR;
                            end
                            else
                                entry_phase_next = ltd_pkg::PH_HEAD;
                        end
                    end
                    ltd_pkg::PH_SKIP_VAR:
                    begin
                        if (!varint_more)
                        begin
                            if (skip_count_reg <= 2'd1)
                            begin
                                skip_count_next  = 2'd0;
                                entry_phase_next = ltd_pkg::PH_HEAD;
                            end
                            else
                                skip_count_next = skip_count_reg - 2'd1;
                        end
                    end
                    ltd_pkg::PH_SKIP_BYTE:
                    begin
                        if (skip_count_reg <= 2'd1)
                        begin
                            skip_count_next  = 2'd0;
                            entry_phase_next = ltd_pkg::PH_HEAD;
                        end
                        else
                            skip_count_next = skip_count_reg - 2'd1;
                    end
                    default:
                    begin
                        // entry head, also any unused phase code
                        address_sum_next = head_sum;
                        if (code == ltd_pkg::CODE_VARINT || code == ltd_pkg::CODE_LONG)
                        begin
                            varint_value_next = 32'd0;
                            varint_shift_next = 5'd0;
                            entry_phase_next  = (code == ltd_pkg::CODE_VARINT)
                                              ? ltd_pkg::PH_VAR_DELTA : ltd_pkg::PH_VAR_LONG;
                        end
                        else
                        begin
                            if ($signed(head_sum) >= $signed(entry_target))
                                decided_next = 1'b1;
                            if (code == ltd_pkg::CODE_NONE)
                                entry_phase_next = ltd_pkg::PH_HEAD;
                            else
                            begin
                                entry_phase_next = ltd_pkg::PH_SKIP_BYTE;
                                if (code >= ltd_pkg::CODE_ONE_LINE)
                                begin
                                    current_line_next = current_line_reg
                                        + {28'd0, code - ltd_pkg::CODE_ONE_LINE};
                                    skip_count_next = 2'd2;
                                end
                                else
                                    skip_count_next = 2'd1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_offset_reg <= 32'd0;
            current_line_reg  <= 32'd0;
            address_sum_reg   <= 32'd0;
            decided_reg       <= 1'b0;
            entry_phase_reg   <= 3'd0;
            held_byte_reg     <= 8'd0;
            varint_value_reg  <= 32'd0;
            varint_shift_reg  <= 5'd0;
            skip_count_reg    <= 2'd0;
        end
        else
        begin
            target_offset_reg <= target_offset_next;
            current_line_reg  <= current_line_next;
            address_sum_reg   <= address_sum_next;
            decided_reg       <= decided_next;
            entry_phase_reg   <= entry_phase_next;
            held_byte_reg     <= held_byte_next;
            varint_value_reg  <= varint_value_next;
            varint_shift_reg  <= varint_shift_next;
            skip_count_reg    <= skip_count_next;
        end
    end

    assign line_number = current_line_reg;

endmodule

[design/bytecode_line_table_decoder.sv]
// bytecode line table decoder top: request register, walk, result register
// depends on ltd_pkg and ltd_walk
//
// channel   dir  handshake         payload
// s_*       in   tvalid / tready   tuser kind, tdata byte/offset/first line
// m_*       out  tvalid / tready   tdata line_number
// cfg_*     in   valid / ready     index, data
//
// one request per cycle while no result stalls: each request is registered, then
// the walk logic updates the state and loads the result register on an end request
// an end request passes the request register, then the result register, to m_tvalid
// reset clears the walk state, the config registers and all valid flags
// a waiting result stalls the request register and the walk; one more request is
// still taken into the request register while the result waits
module bytecode_line_table_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // table_byte[7:0], instr_offset[39:8], first_line[70:40], zero[71]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // line_number[31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic           in_valid_reg;
    ltd_pkg::item_t in_item_reg;
    logic           out_valid_reg;
    logic [31:0]    out_data_reg;
    logic [1:0]     table_format_reg;
    logic [15:0]    code_start_reg;
    logic           pipe_adv;
    logic           proc_en;
    logic [31:0]    cur_line;

    assign pipe_adv  = !out_valid_reg || m_tready;
    assign proc_en   = in_valid_reg && pipe_adv;
    assign s_tready  = !in_valid_reg || pipe_adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_format_reg <= 2'd0;
            code_start_reg   <= 16'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ltd_pkg::CFG_TABLE_FORMAT)
                table_format_reg <= cfg_data[1:0];
            else
                code_start_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.kind         <= s_tuser;
            in_item_reg.table_byte   <= s_tdata[7:0];
            in_item_reg.instr_offset <= s_tdata[39:8];
            in_item_reg.first_line   <= s_tdata[70:40];
        end
    end

    ltd_walk u_walk (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_en           (proc_en),
        .item              (in_item_reg),
        .table_format      (table_format_reg),
        .code_start_offset (code_start_reg),
        .line_number       (cur_line)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_adv)
            out_valid_reg <= in_valid_reg && in_item_reg.kind == ltd_pkg::KIND_END;
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && in_item_reg.kind == ltd_pkg::KIND_END)
            out_data_reg <= cur_line;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a stalled request keeps its slot and contents
    a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !pipe_adv) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("request register lost a stalled request");

    // back pressure only when both slots are full and the result is not taken
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready dropped without a full pipe");

    // every processed end request yields a result next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_en && in_item_reg.kind == ltd_pkg::KIND_END) |=> out_valid_reg)
        else $error("end request gave no result");

    // a result appears only after an end request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_adv && !(in_valid_reg && in_item_reg.kind == ltd_pkg::KIND_END))
        |=> !out_valid_reg)
        else $error("result without an end request");

endmodule
